// ===== src/double_ended_queue_macros.svh =====
// ----------------------------------------------------------------------------
// double_ended_queue_macros.svh
// Assertion macros used by the checker of the double-ended queue.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DEQ_ASSERT_NOW(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DEQ_ASSERT_NEXT(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/deq_pkg.sv =====
// ----------------------------------------------------------------------------
// deq_pkg
// Types, codes and default sizes shared by the double-ended queue files.
// ----------------------------------------------------------------------------
`default_nettype none

package deq_pkg;

    // Default sizes of the entry store.
    localparam int DEPTH_DEFAULT      = 16;
    localparam int DATA_WIDTH_DEFAULT = 32;

    // Fixed widths of the request and response fields.
    localparam int REQ_W       = 3;
    localparam int ITEM_W      = 32;
    localparam int POS_W       = 4;
    localparam int STATUS_W    = 2;
    localparam int COUNT_OUT_W = 5;

    // Request codes; the remaining codes are ignored by the queue.
    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH_BACK  = 3'd0,
        REQ_PUSH_FRONT = 3'd1,
        REQ_DROP_BACK  = 3'd2,
        REQ_DROP_FRONT = 3'd3,
        REQ_READ       = 3'd4
    } req_t;

    // Response status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;       // A request is taken at this edge.
        logic load_direct;  // Load the response register from the request.
        logic load_read;    // Load the response register from the memory read.
    } deq_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic needs_read;   // The pending request is an in-range read.
    } deq_stat_t;

endpackage

`default_nettype wire

// ===== src/deq_if.sv =====
// ----------------------------------------------------------------------------
// deq_if
// Request and response channels of the double-ended queue.
// ----------------------------------------------------------------------------
`default_nettype none

// Request channel: one item is one queue operation.
interface deq_req_if;
    import deq_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [REQ_W-1:0]         req_type;
    logic signed [ITEM_W-1:0] item_value;
    logic [POS_W-1:0]         position;

    modport source (output valid, output req_type, output item_value,
                    output position, input ready);
    modport sink (input valid, input req_type, input item_value,
                  input position, output ready);
endinterface

// Response channel: one item for every request.
interface deq_rsp_if;
    import deq_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [ITEM_W-1:0] read_value;
    logic [STATUS_W-1:0]      status;
    logic [COUNT_OUT_W-1:0]   entry_count;
    logic                     queue_empty;

    modport source (output valid, output read_value, output status,
                    output entry_count, output queue_empty, input ready);
    modport sink (input valid, input read_value, input status,
                  input entry_count, input queue_empty, output ready);
endinterface

`default_nettype wire

// ===== src/deq_ctrl.sv =====
// ----------------------------------------------------------------------------
// deq_ctrl
// Controller of the double-ended queue: request acceptance, the memory
// read wait state and the response valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module deq_ctrl
    import deq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    input  deq_stat_t stat,
    output deq_cmd_t  cmd
);

    typedef enum logic {
        S_IDLE,
        S_READ
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   in_fire;

    // A request is taken when no read is in flight and the response
    // register is free or drains at this edge.
    assign in_ready = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign in_fire  = in_valid && in_ready;

    // Commands to the datapath.
    always_comb
    begin
        cmd.accept      = in_fire;
        cmd.load_direct = in_fire && !stat.needs_read;
        cmd.load_read   = (state_reg == S_READ);
    end

    // Next state and response valid.
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire && stat.needs_read)
                begin
                    state_next = S_READ;
                end
                else if (in_fire)
                begin
                    out_valid_next = 1'b1;
                end
            end
            S_READ:
            begin
                state_next     = S_IDLE;
                out_valid_next = 1'b1;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// ===== src/deq_datapath.sv =====
// ----------------------------------------------------------------------------
// deq_datapath
// Datapath of the double-ended queue: ring pointers, entry memory and the
// response register.
// ----------------------------------------------------------------------------
`default_nettype none

module deq_datapath
    import deq_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEFAULT,
    parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  deq_cmd_t                      cmd,
    output deq_stat_t                     stat,
    input  logic [REQ_W-1:0]              req_type,
    input  logic signed [ITEM_W-1:0]      item_value,
    input  logic [POS_W-1:0]              position,
    output logic signed [ITEM_W-1:0]      read_value,
    output logic [STATUS_W-1:0]           status,
    output logic [COUNT_OUT_W-1:0]        entry_count,
    output logic                          queue_empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = ((PTR_W > POS_W) ? PTR_W : POS_W) + 1;
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    localparam logic [PTR_W-1:0] LAST_SLOT  = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);
    localparam logic [SUM_W-1:0] DEPTH_SUM  = SUM_W'(DEPTH);

    logic [DATA_WIDTH-1:0]    mem [DEPTH];
    logic [DATA_WIDTH-1:0]    rd_data_reg;
    logic [PTR_W-1:0]         front_reg;
    logic [PTR_W-1:0]         front_next;
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic [PTR_W-1:0]         back_slot;
    logic [PTR_W-1:0]         read_slot;
    logic [PTR_W-1:0]         wr_addr;
    logic                     wr_en;
    logic [DATA_WIDTH-1:0]    store_word;
    logic                     pos_in_range;
    status_t                  req_status;
    logic signed [ITEM_W-1:0] rsp_value_reg;
    status_t                  rsp_status_reg;
    logic [COUNT_OUT_W-1:0]   rsp_count_reg;
    logic                     rsp_empty_reg;

    // Slot that lies offset places after the front, modulo the depth.
    // The offset is always below the depth where the slot is used.
    function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] base,
                                                  input logic [SUM_W-1:0] offset);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(base) + offset;
        if (sum >= DEPTH_SUM)
        begin
            sum = sum - DEPTH_SUM;
        end
        return sum[PTR_W-1:0];
    endfunction

    assign back_slot    = wrap_add(front_reg, SUM_W'(count_reg));
    assign read_slot    = wrap_add(front_reg, SUM_W'(position));
    assign pos_in_range = CMP_W'(position) < CMP_W'(count_reg);
    assign store_word   = DATA_WIDTH'($unsigned(item_value));

    // Decode the request against the current ring state.
    always_comb
    begin
        front_next      = front_reg;
        count_next      = count_reg;
        wr_en           = 1'b0;
        wr_addr         = back_slot;
        req_status      = ST_OK;
        stat.needs_read = 1'b0;
        case (req_type)
            REQ_PUSH_BACK:
            begin
                if (count_reg == FULL_COUNT)
                begin
                    req_status = ST_FULL;
                end
                else
                begin
                    wr_en      = 1'b1;
                    count_next = count_reg + 1'b1;
                end
            end
            REQ_PUSH_FRONT:
            begin
                if (count_reg == FULL_COUNT)
                begin
                    req_status = ST_FULL;
                end
                else
                begin
                    front_next = (front_reg == '0) ? LAST_SLOT : front_reg - 1'b1;
                    wr_addr    = front_next;
                    wr_en      = 1'b1;
                    count_next = count_reg + 1'b1;
                end
            end
            REQ_DROP_BACK:
            begin
                if (count_reg == '0)
                begin
                    req_status = ST_EMPTY;
                end
                else
                begin
                    count_next = count_reg - 1'b1;
                end
            end
            REQ_DROP_FRONT:
            begin
                if (count_reg == '0)
                begin
                    req_status = ST_EMPTY;
                end
                else
                begin
                    front_next = (front_reg == LAST_SLOT) ? '0 : front_reg + 1'b1;
                    count_next = count_reg - 1'b1;
                end
            end
            REQ_READ:
            begin
                if (pos_in_range)
                begin
                    stat.needs_read = 1'b1;
                end
                else
                begin
                    req_status = ST_RANGE;
                end
            end
            default:
            begin
                // Unused codes leave the queue as it is.
            end
        endcase
    end

    // Ring pointer and entry count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            count_reg <= '0;
        end
        else if (cmd.accept)
        begin
            front_reg <= front_next;
            count_reg <= count_next;
        end
    end

    // Entry memory with one write port and a registered read port.
    always_ff @(posedge clk)
    begin
        if (cmd.accept && wr_en)
        begin
            mem[wr_addr] <= store_word;
        end
        if (cmd.accept)
        begin
            rd_data_reg <= mem[read_slot];
        end
    end

    // Response register, loaded straight from the request or, in the cycle
    // after the request is taken, from the memory read.
    always_ff @(posedge clk)
    begin
        if (cmd.load_direct)
        begin
            rsp_value_reg  <= '0;
            rsp_status_reg <= req_status;
            rsp_count_reg  <= COUNT_OUT_W'(count_next);
            rsp_empty_reg  <= (count_next == '0);
        end
        else if (cmd.load_read)
        begin
            rsp_value_reg  <= ITEM_W'($signed(rd_data_reg));
            rsp_status_reg <= ST_OK;
            rsp_count_reg  <= COUNT_OUT_W'(count_reg);
            rsp_empty_reg  <= (count_reg == '0);
        end
    end

    assign read_value  = rsp_value_reg;
    assign status      = rsp_status_reg;
    assign entry_count = rsp_count_reg;
    assign queue_empty = rsp_empty_reg;

endmodule

`default_nettype wire

// ===== src/double_ended_queue.sv =====
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded double-ended queue of words kept in a ring buffer.
// ----------------------------------------------------------------------------
// Each request item pushes a word at the back or front, drops the back or
// front entry, or reads the entry at a position counted from the front, and
// yields exactly one response item with the read value, a status code, the
// entry count and an empty flag. Illegal requests are flagged and leave the
// queue unchanged. Pushes, drops, out-of-range reads and unused codes load
// the response register from the request, so they run back to back while
// responses are taken at once; an in-range read waits on the registered read
// port of the entry memory. A new request is taken while the previous
// response is handed over in the same cycle. No clearing pass follows reset.
`default_nettype none

module double_ended_queue
    import deq_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEFAULT,
    parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    deq_req_if.sink     req,
    deq_rsp_if.source   rsp
);

    deq_cmd_t  cmd;
    deq_stat_t stat;

    // Request sequencing and response handshake.
    deq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Ring pointers, entry memory and response register.
    deq_datapath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .req_type    (req.req_type),
        .item_value  (req.item_value),
        .position    (req.position),
        .read_value  (rsp.read_value),
        .status      (rsp.status),
        .entry_count (rsp.entry_count),
        .queue_empty (rsp.queue_empty)
    );

endmodule

`default_nettype wire

// ===== src/deq_checker.sv =====
// ----------------------------------------------------------------------------
// deq_checker
// Port-level checks of the double-ended queue, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "double_ended_queue_macros.svh"

module deq_checker
    import deq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   req_valid,
    input wire logic                   req_ready,
    input wire logic [REQ_W-1:0]       req_type,
    input wire logic                   rsp_valid,
    input wire logic                   rsp_ready,
    input wire logic [STATUS_W-1:0]    rsp_status,
    input wire logic [COUNT_OUT_W-1:0] rsp_count,
    input wire logic                   rsp_empty
);

    localparam logic [COUNT_OUT_W-1:0] FULL_COUNT = COUNT_OUT_W'(DEPTH);

    logic req_fire;

    assign req_fire = req_valid && req_ready;

    // A response item stays offered until it is taken.
    `DEQ_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "response dropped")

    // Any request other than a read answers in the next cycle.
    `DEQ_ASSERT_NEXT(a_fast_rsp, req_fire && (req_type != REQ_READ), rsp_valid,
        "no response after a one-cycle request")

    // A push refused as full reports a full queue.
    `DEQ_ASSERT_NOW(a_full_count, rsp_valid && (rsp_status == ST_FULL),
        rsp_count == FULL_COUNT, "full status with a partial count")

    // A drop refused as empty reports an empty queue.
    `DEQ_ASSERT_NOW(a_empty_flag, rsp_valid && (rsp_status == ST_EMPTY),
        rsp_empty && (rsp_count == '0), "empty status on a filled queue")

endmodule

bind double_ended_queue deq_checker #(
    .DEPTH (DEPTH)
) u_deq_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .req_type   (req.req_type),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_status (rsp.status),
    .rsp_count  (rsp.entry_count),
    .rsp_empty  (rsp.queue_empty)
);

`default_nettype wire

// ===== tb/tb_double_ended_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_double_ended_queue
// Self-checking testbench for the ring-buffer double-ended queue.
// ----------------------------------------------------------------------------
// Request items are driven through the request interface by a shared send
// task. A monitor keeps its own copy of the ring (slots, front slot and fill
// level), works out the response that each accepted request must produce and
// compares every accepted response item with the oldest expected one, field
// by field. Directed tests cover the empty, last-entry and full cases; random
// traffic then walks the queue between empty and full many times, while the
// sender idles between bursts in the first run and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------

module tb_double_ended_queue;
    import deq_pkg::*;

    localparam int CLK_PERIOD  = 8;
    localparam int QDEPTH      = DEPTH_DEFAULT;
    localparam int CYCLE_LIMIT = 300000;

    // Request codes that the queue ignores.
    localparam logic [REQ_W-1:0] REQ_FIRST_SPARE = 3'd5;
    localparam logic [REQ_W-1:0] REQ_LAST_SPARE  = 3'd7;

    // One expected response item.
    typedef struct packed {
        logic signed [ITEM_W-1:0] read_value;
        status_t                  status;
        logic [COUNT_OUT_W-1:0]   entry_count;
        logic                     queue_empty;
    } deq_result_t;

    logic clk;
    logic rst_n;

    deq_req_if req_if ();
    deq_rsp_if rsp_if ();

    double_ended_queue u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    // Shadow of the ring held by the queue.
    logic signed [ITEM_W-1:0] ring_copy [QDEPTH];
    int                       front_slot = 0;
    int                       fill_level = 0;

    deq_result_t pending_results [$];
    int          error_count = 0;
    int          cycle_count = 0;

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #(CLK_PERIOD / 2) clk = ~clk;
        end
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Applies one request to the shadow ring and returns its response.
    function automatic deq_result_t apply_request(logic [REQ_W-1:0] op,
                                                  logic signed [ITEM_W-1:0] word,
                                                  logic [POS_W-1:0] pos);
        deq_result_t res;
        res = '0;
        res.status = ST_OK;
        case (op)
            REQ_PUSH_BACK:
            begin
                if (fill_level == QDEPTH)
                    res.status = ST_FULL;
                else
                begin
                    ring_copy[(front_slot + fill_level) % QDEPTH] = word;
                    fill_level++;
                end
            end
            REQ_PUSH_FRONT:
            begin
                if (fill_level == QDEPTH)
                    res.status = ST_FULL;
                else
                begin
                    front_slot = (front_slot + QDEPTH - 1) % QDEPTH;
                    ring_copy[front_slot] = word;
                    fill_level++;
                end
            end
            REQ_DROP_BACK:
            begin
                if (fill_level == 0)
                    res.status = ST_EMPTY;
                else
                    fill_level--;
            end
            REQ_DROP_FRONT:
            begin
                if (fill_level == 0)
                    res.status = ST_EMPTY;
                else
                begin
                    front_slot = (front_slot + 1) % QDEPTH;
                    fill_level--;
                end
            end
            REQ_READ:
            begin
                if (int'(pos) >= fill_level)
                    res.status = ST_RANGE;
                else
                    res.read_value = ring_copy[(front_slot + int'(pos)) % QDEPTH];
            end
            default:
            begin
                // Spare codes leave the queue alone.
            end
        endcase
        res.entry_count = fill_level[COUNT_OUT_W-1:0];
        res.queue_empty = (fill_level == 0);
        return res;
    endfunction

    task automatic report_mismatch(string field, longint want, longint got);
        error_count++;
        $display("%0t: %s mismatch: expected %0d, actual %0d",
                 $time, field, want, got);
    endtask

    // Monitor: predicts each accepted request, then checks each accepted
    // response against the oldest prediction.
    always @(posedge clk)
    begin
        deq_result_t want;
        if (rst_n)
        begin
            if (req_if.valid && req_if.ready)
                pending_results.insert(pending_results.size(),
                                       apply_request(req_if.req_type,
                                                     req_if.item_value,
                                                     req_if.position));
            if (rsp_if.valid && rsp_if.ready)
            begin
                if (pending_results.size() == 0)
                begin
                    error_count++;
                    $display("%0t: response item with none expected: value %0d status %0d",
                             $time, rsp_if.read_value, rsp_if.status);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (rsp_if.read_value !== want.read_value)
                        report_mismatch("read_value", want.read_value, rsp_if.read_value);
                    if (rsp_if.status !== want.status)
                        report_mismatch("status", want.status, rsp_if.status);
                    if (rsp_if.entry_count !== want.entry_count)
                        report_mismatch("entry_count", want.entry_count, rsp_if.entry_count);
                    if (rsp_if.queue_empty !== want.queue_empty)
                        report_mismatch("queue_empty", want.queue_empty, rsp_if.queue_empty);
                end
            end
        end
    end

    // Receiver: alternates open stretches, stalls and random toggling.
    initial
    begin
        int run;
        int mode;
        rsp_if.ready = 1'b0;
        forever
        begin
            mode = $urandom_range(0, 3);
            case (mode)
                0:       run = $urandom_range(10, 60);
                1:       run = $urandom_range(1, 8);
                2:       run = $urandom_range(10, 40);
                default: run = $urandom_range(1, 4);
            endcase
            repeat (run)
            begin
                @(negedge clk);
                case (mode)
                    0:       rsp_if.ready <= 1'b1;
                    1:       rsp_if.ready <= 1'b0;
                    2:       rsp_if.ready <= ($urandom_range(0, 2) != 0);
                    default: rsp_if.ready <= 1'b1;
                endcase
            end
        end
    end

    // Sends one request item; starts and returns at a falling edge.
    task automatic send_item(logic [REQ_W-1:0] op, logic signed [ITEM_W-1:0] word,
                             logic [POS_W-1:0] pos);
        req_if.valid      <= 1'b1;
        req_if.req_type   <= op;
        req_if.item_value <= word;
        req_if.position   <= pos;
        do
            @(posedge clk);
        while (!req_if.ready);
        @(negedge clk);
    endtask

    task automatic idle_sender(int cycles);
        req_if.valid <= 1'b0;
        repeat (cycles) @(negedge clk);
    endtask

    // Holds the sender off until every expected response has come back.
    task automatic wait_for_drain();
        if (pending_results.size() != 0)
        begin
            req_if.valid <= 1'b0;
            while (pending_results.size() != 0)
                @(negedge clk);
        end
    endtask

    // Drops and an in-range-looking read on an empty queue.
    task automatic test_empty_queue();
        send_item(REQ_DROP_BACK, 32'sd0, 4'd0);
        send_item(REQ_DROP_FRONT, 32'sd0, 4'd0);
        send_item(REQ_READ, 32'sd0, 4'd0);
    endtask

    // Dropping the only entry from either end leaves the queue empty.
    task automatic test_last_entry_drop();
        send_item(REQ_PUSH_FRONT, 32'sh1234_5678, 4'd0);
        send_item(REQ_DROP_BACK, 32'sd0, 4'd0);
        send_item(REQ_PUSH_BACK, -32'sd2, 4'd0);
        send_item(REQ_DROP_FRONT, 32'sd0, 4'd0);
    endtask

    // Fills the queue from both ends, then pushes while full and reads
    // both ends of the full ring.
    task automatic test_fill_to_full();
        logic signed [ITEM_W-1:0] extremes [4] = '{32'sh7FFF_FFFF, 32'sh8000_0000,
                                                   32'sh0, -32'sd1};
        logic signed [ITEM_W-1:0] word;
        for (int i = 0; i < QDEPTH; i++)
        begin
            word = (i < 4) ? extremes[i] : $urandom;
            send_item((i % 2 == 0) ? REQ_PUSH_BACK : REQ_PUSH_FRONT, word, 4'd0);
        end
        send_item(REQ_PUSH_BACK, 32'sh5555_5555, 4'd0);
        send_item(REQ_PUSH_FRONT, 32'shAAAA_AAAA, 4'd0);
        send_item(REQ_READ, 32'sd0, 4'd15);
        send_item(REQ_READ, 32'sd0, 4'd0);
    endtask

    // Random request with its mix biased toward growing or shrinking.
    task automatic send_random_item(bit growing);
        logic [REQ_W-1:0]         op;
        logic [POS_W-1:0]         pos;
        logic signed [ITEM_W-1:0] word;
        int                       roll;
        roll = $urandom_range(0, 99);
        if (roll < 4)
            op = REQ_W'($urandom_range(REQ_FIRST_SPARE, REQ_LAST_SPARE));
        else if (roll < 30)
            op = REQ_READ;
        else if ($urandom_range(0, 99) < (growing ? 75 : 25))
            op = $urandom_range(0, 1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT;
        else
            op = $urandom_range(0, 1) ? REQ_DROP_BACK : REQ_DROP_FRONT;

        // Most reads land on a stored entry; the rest may fall past the count.
        if (fill_level > 0 && $urandom_range(0, 3) != 0)
            pos = POS_W'($urandom_range(0, fill_level - 1));
        else
            pos = POS_W'($urandom_range(0, 15));

        case ($urandom_range(0, 19))
            0:       word = 32'sh7FFF_FFFF;
            1:       word = 32'sh8000_0000;
            2:       word = 32'sh0;
            3:       word = -32'sd1;
            default: word = $urandom;
        endcase
        send_item(op, word, pos);
    endtask

    // Random traffic in bursts; a zero gap limit sends back to back.
    task automatic test_random_traffic(int total, int max_gap);
        int  sent;
        int  burst;
        bit  growing;
        sent    = 0;
        growing = 1'b1;
        while (sent < total)
        begin
            burst = $urandom_range(1, 16);
            for (int i = 0; i < burst && sent < total; i++)
            begin
                if (fill_level == QDEPTH)
                    growing = 1'b0;
                else if (fill_level == 0)
                    growing = 1'b1;
                send_random_item(growing);
                sent++;
            end
            if (max_gap > 0 && $urandom_range(0, 2) != 0)
                idle_sender($urandom_range(1, max_gap));
        end
    endtask

    // Test sequence.
    initial
    begin
        req_if.valid      = 1'b0;
        req_if.req_type   = REQ_PUSH_BACK;
        req_if.item_value = '0;
        req_if.position   = '0;
        rst_n             = 1'b0;
        for (int i = 0; i < QDEPTH; i++)
            ring_copy[i] = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_empty_queue();
        test_last_entry_drop();
        test_fill_to_full();
        wait_for_drain();
        test_random_traffic(900, 6);
        wait_for_drain();
        test_random_traffic(750, 0);

        // Let the last responses arrive, then allow for stray ones.
        wait_for_drain();
        repeat (20) @(negedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
